### hdl/histogram_equalizer_macros.svh
// assertion macros shared by the histogram equalizer rtl
// no dependencies; included by files that carry concurrent checks
`ifndef HISTOGRAM_EQUALIZER_MACROS_SVH
`define HISTOGRAM_EQUALIZER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define HEQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define HEQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/heq_pkg.sv
// shared constants, types and control structs of the histogram equalizer
// no dependencies; used by the interfaces, controller, datapath and top level
`default_nettype none

package heq_pkg;

  localparam int unsigned MAX_PIXELS    = 4194304;
  localparam int unsigned PIX_W         = 8;
  localparam int unsigned LEVELS        = 2 ** PIX_W;
  localparam int unsigned CNT_W         = 23;
  localparam int unsigned COUNT_MAX     = 2 ** CNT_W - 1;
  localparam int unsigned PIXEL_CAP_INT = (MAX_PIXELS < COUNT_MAX) ? MAX_PIXELS : COUNT_MAX;
  // scaled numerator (cdf - min) * 255 and divisor range << (PIX_W - 1)
  localparam int unsigned NUM_W         = CNT_W + PIX_W;
  localparam int unsigned DVS_W         = CNT_W + PIX_W - 1;
  localparam int unsigned STEP_W        = $clog2(PIX_W);

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [NUM_W-1:0]  num_t;
  typedef logic [DVS_W-1:0]  dvs_t;
  typedef logic [STEP_W-1:0] step_t;

  localparam cnt_t  PIXEL_CAP  = CNT_W'(PIXEL_CAP_INT);
  localparam pix_t  LAST_INDEX = PIX_W'(LEVELS - 1);
  localparam step_t LAST_STEP  = STEP_W'(PIX_W - 1);

  typedef enum logic {
    MODE_ACCUM = 1'b0,
    MODE_MAP   = 1'b1
  } mode_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic take;        // latch the accepted input transaction
    logic bin_sel_idx; // bin read address from the sweep index
    logic acc_wr;      // write bin + 1 and bump the pixel total
    logic build_init;  // reset sweep index, running sum and minimum
    logic cdf_step;    // add the bin just read to the running sum
    logic diff_step;   // form cdf - min and total - min
    logic scale_step;  // multiply by 255, load divisor
    logic div_step;    // one restoring division step
    logic map_wr;      // write map entry, advance sweep index
    logic out_load;    // load the output register from the map read
    logic clr;         // clear histogram and pixel total
  } heq_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic last;     // latched last flag
    logic at_cap;   // pixel total reached the cap
    logic div_done; // final division step this cycle
    logic idx_done; // sweep at the last map entry
    logic out_busy; // output register full and not being taken
  } heq_sts_t;

endpackage

`default_nettype wire

### hdl/heq_in_if.sv
// input pixel channel: valid/ready handshake with mode, pixel and last
// depends on heq_pkg
`default_nettype none

interface heq_in_if;
  logic          valid;
  logic          ready;
  logic          mode;
  heq_pkg::pix_t pixel;
  logic          last;

  modport source (output valid, output mode, output pixel, output last, input ready);
  modport sink   (input valid, input mode, input pixel, input last, output ready);
endinterface

`default_nettype wire

### hdl/heq_out_if.sv
// output pixel channel: valid/ready handshake with mapped pixel and last
// depends on heq_pkg
`default_nettype none

interface heq_out_if;
  logic          valid;
  logic          ready;
  heq_pkg::pix_t out_pixel;
  logic          out_last;

  modport source (output valid, output out_pixel, output out_last, input ready);
  modport sink   (input valid, input out_pixel, input out_last, output ready);
endinterface

`default_nettype wire

### hdl/heq_ctrl.sv
// sequencing state machine: accumulate, map build sweep and map lookup
// depends on heq_pkg; drives heq_datapath through heq_cmd_t
`default_nettype none

module heq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_mode_i,
  output logic              in_ready_o,
  input  heq_pkg::heq_sts_t sts_i,
  output heq_pkg::heq_cmd_t cmd_o
);
  import heq_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_ACC_RD  = 11'b000_0000_0010,
    S_ACC_WR  = 11'b000_0000_0100,
    S_B_RD    = 11'b000_0000_1000,
    S_B_CDF   = 11'b000_0001_0000,
    S_B_DIFF  = 11'b000_0010_0000,
    S_B_SCALE = 11'b000_0100_0000,
    S_B_DIV   = 11'b000_1000_0000,
    S_B_WR    = 11'b001_0000_0000,
    S_LUT_RD  = 11'b010_0000_0000,
    S_LUT_OUT = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = (in_mode_i == MODE_MAP) ? S_LUT_RD : S_ACC_RD;
        end
      end
      S_ACC_RD: begin
        state_d = S_ACC_WR;
      end
      S_ACC_WR: begin
        cmd_o.acc_wr = !sts_i.at_cap;
        if (sts_i.last) begin
          cmd_o.build_init = 1'b1;
          state_d          = S_B_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_B_RD: begin
        cmd_o.bin_sel_idx = 1'b1;
        state_d           = S_B_CDF;
      end
      S_B_CDF: begin
        cmd_o.cdf_step = 1'b1;
        state_d        = S_B_DIFF;
      end
      S_B_DIFF: begin
        cmd_o.diff_step = 1'b1;
        state_d         = S_B_SCALE;
      end
      S_B_SCALE: begin
        cmd_o.scale_step = 1'b1;
        state_d          = S_B_DIV;
      end
      S_B_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_B_WR;
        end
      end
      S_B_WR: begin
        cmd_o.map_wr = 1'b1;
        state_d      = sts_i.idx_done ? S_IDLE : S_B_RD;
      end
      S_LUT_RD: begin
        state_d = S_LUT_OUT;
      end
      S_LUT_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          cmd_o.clr      = sts_i.last;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### hdl/heq_datapath.sv
// histogram memory, map memory, running sum, serial divider, output register
// depends on heq_pkg and histogram_equalizer_macros.svh; driven by heq_ctrl
`default_nettype none
`include "histogram_equalizer_macros.svh"

module heq_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  heq_pkg::heq_cmd_t cmd_i,
  output heq_pkg::heq_sts_t sts_o,
  input  heq_pkg::pix_t     in_pixel_i,
  input  logic              in_last_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output heq_pkg::pix_t     out_pixel_o,
  output logic              out_last_o
);
  import heq_pkg::*;

  cnt_t              bin_mem [LEVELS];
  logic [LEVELS-1:0] bin_vld_q;
  pix_t              map_mem [LEVELS];

  pix_t  pixel_q;
  logic  last_q;
  pix_t  bin_addr;
  cnt_t  bin_rd_q;
  logic  bin_rd_vld_q;
  cnt_t  bin_val;
  pix_t  map_rd_q;
  cnt_t  total_q;
  pix_t  idx_q;
  cnt_t  cdf_q;
  cnt_t  cdf_nxt;
  cnt_t  min_q;
  cnt_t  range_q;
  num_t  rem_q;
  dvs_t  dvs_q;
  pix_t  quo_q;
  step_t step_q;
  logic  div_ge;
  logic  out_valid_q;
  pix_t  out_pixel_q;
  logic  out_last_q;

  // input transaction capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      pixel_q <= in_pixel_i;
      last_q  <= in_last_i;
    end
  end

  // histogram memory with registered read
  assign bin_addr = cmd_i.bin_sel_idx ? idx_q : pixel_q;

  always_ff @(posedge clk_i) begin
    bin_rd_q <= bin_mem[bin_addr];
    if (cmd_i.acc_wr) begin
      bin_mem[pixel_q] <= bin_val + cnt_t'(1);
    end
  end

  // per-bin valid bits: an unwritten or cleared bin reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_vld_q    <= '0;
      bin_rd_vld_q <= 1'b0;
    end else begin
      bin_rd_vld_q <= bin_vld_q[bin_addr];
      if (cmd_i.clr) begin
        bin_vld_q <= '0;
      end else if (cmd_i.acc_wr) begin
        bin_vld_q[pixel_q] <= 1'b1;
      end
    end
  end

  assign bin_val = bin_rd_vld_q ? bin_rd_q : '0;

  // pixel total
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (cmd_i.clr) begin
      total_q <= '0;
    end else if (cmd_i.acc_wr) begin
      total_q <= total_q + cnt_t'(1);
    end
  end

  // running sum; the first nonzero sum is the minimum
  assign cdf_nxt = cdf_q + bin_val;

  always_ff @(posedge clk_i) begin
    if (cmd_i.build_init) begin
      idx_q <= '0;
      cdf_q <= '0;
      min_q <= '0;
    end else begin
      if (cmd_i.cdf_step) begin
        cdf_q <= cdf_nxt;
        if (min_q == '0) begin
          min_q <= cdf_nxt;
        end
      end
      if (cmd_i.map_wr) begin
        idx_q <= idx_q + pix_t'(1);
      end
    end
  end

  // scale and restoring division, one quotient bit a cycle
  assign div_ge = rem_q >= NUM_W'(dvs_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff_step) begin
      rem_q   <= NUM_W'(cdf_q - min_q);
      range_q <= total_q - min_q;
    end else if (cmd_i.scale_step) begin
      rem_q  <= (rem_q << PIX_W) - rem_q;
      dvs_q  <= {range_q, {(PIX_W-1){1'b0}}};
      quo_q  <= '0;
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      if (div_ge) begin
        rem_q <= rem_q - NUM_W'(dvs_q);
      end
      quo_q  <= {quo_q[PIX_W-2:0], div_ge};
      dvs_q  <= dvs_q >> 1;
      step_q <= step_q + step_t'(1);
    end
  end

  // map memory with registered read; zero range maps everything to zero
  always_ff @(posedge clk_i) begin
    map_rd_q <= map_mem[pixel_q];
    if (cmd_i.map_wr) begin
      map_mem[idx_q] <= (range_q == '0) ? '0 : quo_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_pixel_q <= map_rd_q;
      out_last_q  <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_pixel_q;
  assign out_last_o  = out_last_q;

  // status
  assign sts_o.last     = last_q;
  assign sts_o.at_cap   = total_q >= PIXEL_CAP;
  assign sts_o.div_done = step_q == LAST_STEP;
  assign sts_o.idx_done = idx_q == LAST_INDEX;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  // checks
  `HEQ_ASSERT_IMP(a_out_no_overwrite, clk_i, rst_ni, cmd_i.out_load, !(out_valid_q && !out_ready_i), "output register overwritten while held")
  `HEQ_ASSERT_IMP(a_total_capped, clk_i, rst_ni, 1'b1, total_q <= PIXEL_CAP, "pixel total above cap")
  `HEQ_ASSERT_NXT(a_clear_all, clk_i, rst_ni, cmd_i.clr, (total_q == '0) && (bin_vld_q == '0), "histogram not cleared")
  `HEQ_ASSERT_IMP(a_div_rem, clk_i, rst_ni, cmd_i.map_wr && (range_q != '0), rem_q < NUM_W'(range_q), "division remainder not below divisor")

endmodule

`default_nettype wire

### hdl/histogram_equalizer.sv
// top level of the two-pass 8-bit histogram equalizer
// depends on heq_pkg, heq_in_if, heq_out_if, heq_ctrl and heq_datapath
//
//   channel | dir | handshake    | payload
//   in_i    | in  | valid, ready | mode, pixel, last
//   out_o   | out | valid, ready | out_pixel, out_last
//
// a mode 0 pixel is accepted, its bin read and written back; a mode 1 pixel
// is accepted, its map entry read and the output register loaded once free.
// the last mode 0 pixel adds a map build over all 256 entries: one bin read,
// sum, difference, scale, 8 bit-serial divide steps and a map write each.
// reset clears the histogram at once through per-bin valid bits, no sweep.
// a new pixel is accepted while a mapped result waits in the output register.
`default_nettype none

module histogram_equalizer (
  input  logic      clk_i,
  input  logic      rst_ni,
  heq_in_if.sink    in_i,
  heq_out_if.source out_o
);
  import heq_pkg::*;

  heq_cmd_t cmd;
  heq_sts_t sts;
  logic     in_ready;

  // sequencing
  heq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_mode_i  (in_i.mode),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // storage and arithmetic
  heq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_pixel_i  (in_i.pixel),
    .in_last_i   (in_i.last),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_pixel_o (out_o.out_pixel),
    .out_last_o  (out_o.out_last)
  );

  assign in_i.ready = in_ready;

endmodule

`default_nettype wire

### sim/tb.sv
// testbench for the histogram equalizer: directed frames, then random frames
// checked against a behavioral equalizer; depends on heq_pkg, heq_in_if, heq_out_if
module tb;
  import heq_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned TAIL_CYCLES  = 4000;
  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int unsigned SCRIPT_ROWS  = 25;

  typedef enum int unsigned {
    SPREAD_UNIFORM,
    SPREAD_NARROW,
    SPREAD_FLAT,
    SPREAD_EDGES
  } spread_e;

  // one directed transaction, with a typed expectation where it is obvious
  typedef struct {
    mode_e mode;
    pix_t  pixel;
    logic  eof;
    logic  typed;
    pix_t  want;
  } script_row_t;

  typedef struct {
    pix_t px;
    logic eof;
  } mapped_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  heq_in_if  in_bus ();
  heq_out_if out_bus ();

  histogram_equalizer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // behavioral copy of the histogram, pixel total and level map
  cnt_t        bin_tally [LEVELS];
  cnt_t        pixel_sum;
  pix_t        level_lut [LEVELS];
  mapped_t     mapped_q [$];

  logic        row_typed;
  pix_t        row_want;
  int unsigned err_count;
  int unsigned sent_count;
  int unsigned calm_left;
  int unsigned cycle_count;

  // frames whose results are plain to see; the rest go through the predictor
  script_row_t script [SCRIPT_ROWS] = '{
    // two extremes: 0 maps to 0, 255 to 255, middle sits on min_cdf
    '{MODE_ACCUM, 8'd0,    1'b0, 1'b0, 8'd0},
    '{MODE_ACCUM, 8'd255,  1'b1, 1'b0, 8'd0},
    '{MODE_MAP,   8'd0,    1'b0, 1'b1, 8'd0},
    '{MODE_MAP,   8'd255,  1'b0, 1'b1, 8'd255},
    '{MODE_MAP,   8'd128,  1'b0, 1'b1, 8'd0},
    '{MODE_MAP,   8'd255,  1'b1, 1'b1, 8'd255},
    // single pixel frame: zero range
    '{MODE_ACCUM, 8'd77,   1'b1, 1'b0, 8'd0},
    '{MODE_MAP,   8'd77,   1'b0, 1'b1, 8'd0},
    '{MODE_MAP,   8'd255,  1'b1, 1'b1, 8'd0},
    // repeated pass 0 keeps accumulating, bins below min_cdf map to zero
    '{MODE_ACCUM, 8'd10,   1'b0, 1'b0, 8'd0},
    '{MODE_ACCUM, 8'd10,   1'b1, 1'b0, 8'd0},
    '{MODE_ACCUM, 8'd200,  1'b1, 1'b0, 8'd0},
    '{MODE_MAP,   8'd0,    1'b0, 1'b1, 8'd0},
    '{MODE_MAP,   8'd200,  1'b0, 1'b1, 8'd255},
    '{MODE_MAP,   8'd10,   1'b0, 1'b1, 8'd0},
    // pass 1 without last leaves the histogram in place
    '{MODE_ACCUM, 8'd100,  1'b1, 1'b0, 8'd0},
    '{MODE_MAP,   8'd100,  1'b0, 1'b1, 8'd127},
    '{MODE_MAP,   8'd150,  1'b0, 1'b1, 8'd127},
    '{MODE_MAP,   8'd200,  1'b1, 1'b1, 8'd255},
    // alternating bit patterns
    '{MODE_ACCUM, 8'hA5,   1'b0, 1'b0, 8'd0},
    '{MODE_ACCUM, 8'h5A,   1'b0, 1'b0, 8'd0},
    '{MODE_ACCUM, 8'hF0,   1'b0, 1'b0, 8'd0},
    '{MODE_ACCUM, 8'h0F,   1'b1, 1'b0, 8'd0},
    '{MODE_MAP,   8'h5A,   1'b0, 1'b0, 8'd0},
    '{MODE_MAP,   8'hF0,   1'b1, 1'b0, 8'd0}
  };

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at cycle %0d: %s", cycle_count, what);
    err_count++;
  endtask

  // cumulative sum, first nonzero cdf, then scale each level into 0..255
  function automatic void rebuild_levels();
    int unsigned     run;
    int unsigned     floor_cdf;
    int unsigned     span;
    bit              seen;
    int unsigned     cdf [LEVELS];
    longint unsigned scaled;
    run = 0;
    floor_cdf = 0;
    seen = 1'b0;
    for (int i = 0; i < LEVELS; i++) begin
      run += bin_tally[i];
      cdf[i] = run;
      if (!seen && run != 0) begin
        floor_cdf = run;
        seen = 1'b1;
      end
    end
    if (!seen || pixel_sum <= floor_cdf) begin
      foreach (level_lut[i]) level_lut[i] = '0;
      return;
    end
    span = pixel_sum - floor_cdf;
    for (int i = 0; i < LEVELS; i++) begin
      if (cdf[i] < floor_cdf) begin
        level_lut[i] = '0;
      end else begin
        scaled = (longint'(cdf[i] - floor_cdf) * 255) / span;
        level_lut[i] = (scaled > 255) ? 8'd255 : pix_t'(scaled);
      end
    end
  endfunction

  // predictor: update state for one accepted input transaction
  task automatic take_pixel(input logic mode, input pix_t pix, input logic eof,
                            input logic typed, input pix_t typed_px);
    mapped_t entry;
    if (mode == MODE_ACCUM) begin
      if (pixel_sum < PIXEL_CAP) begin
        bin_tally[pix] = bin_tally[pix] + 1'b1;
        pixel_sum = pixel_sum + 1'b1;
      end
      if (eof) rebuild_levels();
    end else begin
      entry.px  = typed ? typed_px : level_lut[pix];
      entry.eof = eof;
      mapped_q.push_back(entry);
      if (eof) begin
        foreach (bin_tally[i]) bin_tally[i] = '0;
        pixel_sum = '0;
      end
    end
  endtask

  task automatic check_mapped(input pix_t got_px, input logic got_eof);
    mapped_t want;
    if (mapped_q.size() == 0) begin
      report_mismatch($sformatf("unexpected output pixel %0d last %b", got_px, got_eof));
      return;
    end
    want = mapped_q.pop_front();
    if (got_px !== want.px)
      report_mismatch($sformatf("out_pixel %0d, expected %0d", got_px, want.px));
    if (got_eof !== want.eof)
      report_mismatch($sformatf("out_last %b, expected %b", got_eof, want.eof));
  endtask

  // monitor both channels at the clock edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
        check_mapped(out_bus.out_pixel, out_bus.out_last);
      if (in_bus.valid === 1'b1 && in_bus.ready === 1'b1)
        take_pixel(in_bus.mode, in_bus.pixel, in_bus.last, row_typed, row_want);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // sender gaps: mostly short, a few long, with calm stretches of none
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic send_pixel(input logic mode, input pix_t pix, input logic eof,
                            input logic typed, input pix_t want);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.mode  <= mode;
    in_bus.pixel <= pix;
    in_bus.last  <= eof;
    row_typed    <= typed;
    row_want     <= want;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    sent_count++;
  endtask

  // hold the input off until every mapped pixel has come out
  task automatic drain_outputs();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (mapped_q.size() != 0);
  endtask

  function automatic pix_t pick_level(input spread_e spread, input pix_t base);
    int lo;
    int hi;
    case (spread)
      SPREAD_NARROW: begin
        lo = (base < 8) ? 0 : base - 8;
        hi = (base > 247) ? 255 : base + 8;
        return pix_t'($urandom_range(lo, hi));
      end
      SPREAD_FLAT: begin
        return base;
      end
      SPREAD_EDGES: begin
        return $urandom_range(0, 1) ? pix_t'($urandom_range(250, 255))
                                    : pix_t'($urandom_range(0, 5));
      end
      default: begin
        return pix_t'($urandom_range(0, 255));
      end
    endcase
  endfunction

  // output ready: long ready stretches, short stalls and a few long ones
  initial begin
    int unsigned hold;
    out_bus.ready <= 1'b0;
    @(posedge clk_i);
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 9) < 7) begin
        out_bus.ready <= 1'b1;
        hold = $urandom_range(1, 20);
      end else begin
        out_bus.ready <= 1'b0;
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
      repeat (hold) @(posedge clk_i);
    end
  end

  // stimulus
  initial begin
    spread_e     spread;
    pix_t        base;
    int unsigned n_accum;
    int unsigned n_map;
    logic        eof;
    rst_ni       <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.mode  <= MODE_ACCUM;
    in_bus.pixel <= '0;
    in_bus.last  <= 1'b0;
    row_typed    <= 1'b0;
    row_want     <= '0;
    err_count    = 0;
    sent_count   = 0;
    calm_left    = 0;
    cycle_count  = 0;
    pixel_sum    = '0;
    foreach (bin_tally[i]) bin_tally[i] = '0;
    foreach (level_lut[i]) level_lut[i] = '0;

    // reset
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames
    foreach (script[i])
      send_pixel(script[i].mode, script[i].pixel, script[i].eof,
                 script[i].typed, script[i].want);
    drain_outputs();

    // random frames: pass 0 then pass 1, with broken sequences mixed in
    while (sent_count < SCRIPT_ROWS + RANDOM_ITEMS) begin
      spread  = spread_e'($urandom_range(0, 3));
      base    = pix_t'($urandom_range(0, 255));
      n_accum = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 30);
      for (int k = 0; k < n_accum; k++) begin
        eof = (k == n_accum - 1) || ($urandom_range(0, 199) == 0);
        send_pixel(MODE_ACCUM, pick_level(spread, base), eof, 1'b0, '0);
      end
      // another pass 0 on top of the same histogram
      if ($urandom_range(0, 7) == 0) begin
        n_accum = $urandom_range(1, 8);
        for (int k = 0; k < n_accum; k++)
          send_pixel(MODE_ACCUM, pick_level(spread, base), k == n_accum - 1, 1'b0, '0);
      end
      // stray pass 0 pixel with no last mark
      if ($urandom_range(0, 9) == 0)
        send_pixel(MODE_ACCUM, pix_t'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
      n_map = $urandom_range(1, 30);
      for (int k = 0; k < n_map; k++) begin
        eof = ((k == n_map - 1) && ($urandom_range(0, 99) < 85)) ||
              ($urandom_range(0, 99) == 0);
        base = ($urandom_range(0, 3) == 0) ? pick_level(spread, base)
                                           : pix_t'($urandom_range(0, 255));
        send_pixel(MODE_MAP, base, eof, 1'b0, '0);
      end
      if ($urandom_range(0, 11) == 0) drain_outputs();
    end

    // wait for outstanding results, then let any map build finish
    drain_outputs();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0 && mapped_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
